// ===== design/spi_pkg.sv =====
package spi_pkg;

	// Alpha clamp flags that ride along with an item through the divider.
	typedef struct packed {
		logic zero;   // render at or before the older snapshot
		logic full;   // render at or after the newer one, or empty or reversed interval
	} clamp_t;

	// Quotient bits resolved in each divider stage.
	localparam int DIV_BITS_PER_STAGE = 2;

endpackage

// ===== design/spi_alpha_div.sv =====
module spi_alpha_div #(
	parameter int TIME_BITS    = 32,
	parameter int FRAC_BITS    = 16,
	parameter int PAYLOAD_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [TIME_BITS-1:0]    dur,
	input  logic [TIME_BITS-1:0]    rem,
	input  spi_pkg::clamp_t         in_clamp,
	input  logic [PAYLOAD_BITS-1:0] in_payload,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [FRAC_BITS-1:0]    quotient,
	output spi_pkg::clamp_t         out_clamp,
	output logic [PAYLOAD_BITS-1:0] out_payload
);
	import spi_pkg::*;

	localparam int NS = (FRAC_BITS + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;

	// Index 0 is the input port; index k is the register of stage k.
	logic                    vld_s [NS+1];
	logic                    adv   [NS+2];
	logic [TIME_BITS-1:0]    dur_s [NS+1];
	logic [TIME_BITS-1:0]    rem_s [NS+1];
	logic [FRAC_BITS-1:0]    quo_s [NS+1];
	clamp_t                  clp_s [NS+1];
	logic [PAYLOAD_BITS-1:0] pld_s [NS+1];

	assign vld_s[0] = in_valid;
	assign dur_s[0] = dur;
	assign rem_s[0] = rem;
	assign quo_s[0] = '0;
	assign clp_s[0] = in_clamp;
	assign pld_s[0] = in_payload;

	assign adv[0]    = 1'b0;
	assign adv[NS+1] = out_ready;
	assign in_ready  = adv[1];

	genvar k;
	generate
		for (k = 0; k < NS; k++) begin : g_stage
			localparam int DONE  = k * DIV_BITS_PER_STAGE;
			localparam int STEPS = (FRAC_BITS - DONE >= DIV_BITS_PER_STAGE) ?
				DIV_BITS_PER_STAGE : FRAC_BITS - DONE;

			logic [TIME_BITS-1:0] rem_nx;
			logic [FRAC_BITS-1:0] quo_nx;

			assign adv[k+1] = !vld_s[k+1] || adv[k+2];

			// Restoring division: shift, compare, subtract once per bit.
			always_comb begin : step
				logic [TIME_BITS:0]   r;
				logic [FRAC_BITS-1:0] q;
				r = {1'b0, rem_s[k]};
				q = quo_s[k];
				for (int i = 0; i < STEPS; i++) begin
					r = {r[TIME_BITS-1:0], 1'b0};
					q = {q[FRAC_BITS-2:0], 1'b0};
					if (r >= {1'b0, dur_s[k]}) begin
						r    = r - {1'b0, dur_s[k]};
						q[0] = 1'b1;
					end
				end
				rem_nx = r[TIME_BITS-1:0];
				quo_nx = q;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k+1] <= 1'b0;
				end else if (adv[k+1]) begin
					vld_s[k+1] <= vld_s[k];
				end
			end

			always_ff @(posedge clk) begin
				if (adv[k+1] && vld_s[k]) begin
					dur_s[k+1] <= dur_s[k];
					rem_s[k+1] <= rem_nx;
					quo_s[k+1] <= quo_nx;
					clp_s[k+1] <= clp_s[k];
					pld_s[k+1] <= pld_s[k];
				end
			end
		end
	endgenerate

	assign out_valid   = vld_s[NS];
	assign quotient    = quo_s[NS];
	assign out_clamp   = clp_s[NS];
	assign out_payload = pld_s[NS];

endmodule

// ===== design/snapshot_pose_interpolator.sv =====
// Snapshot pose interpolator: blends two timestamped poses at a render time.
// Pipeline: the compare register, the two-bit-per-stage alpha divider, then the
//   multiply register and the output register.
// Throughput: one item per cycle while m_axis_tready is high; every stage holds under backpressure on its own.
// Reset: arst_n clears all stage valid bits asynchronously; data registers keep state.
module snapshot_pose_interpolator #(
	parameter int TIME_BITS       = 32,
	parameter int POS_BITS        = 32,
	parameter int ANGLE_BITS      = 16,
	parameter int ALPHA_FRAC_BITS = 16,
	localparam int IN_W  = 3 * TIME_BITS + 6 * POS_BITS + 2 * ANGLE_BITS,
	localparam int OUT_W = 3 * POS_BITS + ANGLE_BITS,
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// older_time, newer_time, sample_time, older_x, older_y, older_z,
	// newer_x, newer_y, newer_z, older_heading, newer_heading (lowest first)
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// out_x, out_y, out_z, out_heading (lowest first), zero padded
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);
	import spi_pkg::*;

	localparam int T = TIME_BITS;
	localparam int P = POS_BITS;
	localparam int A = ANGLE_BITS;
	localparam int F = ALPHA_FRAC_BITS;
	localparam int PROD_W = P + F + 3;
	localparam int HPROD_W = A + F + 3;

	localparam logic signed [A+1:0] HALF_TURN = (A+2)'(64'd1 << (A - 1));
	localparam logic signed [A+1:0] FULL_TURN = (A+2)'(64'd1 << A);
	localparam logic [F:0]          ALPHA_ONE = (F+1)'(64'd1 << F);

	// Everything the blend needs, carried alongside the divider.
	typedef struct packed {
		logic [A:0]   hd;
		logic [A-1:0] oh;
		logic [P:0]   dz;
		logic [P:0]   dy;
		logic [P:0]   dx;
		logic [P-1:0] oz;
		logic [P-1:0] oy;
		logic [P-1:0] ox;
	} carry_t;

	// ---------------- field unpacking ----------------
	logic [T-1:0] t_old, t_new, t_ren;
	logic [P-1:0] ox, oy, oz, nx, ny, nz;
	logic [A-1:0] oh, nh;

	assign t_old = s_axis_tdata[0*T +: T];
	assign t_new = s_axis_tdata[1*T +: T];
	assign t_ren = s_axis_tdata[2*T +: T];
	assign ox    = s_axis_tdata[3*T + 0*P +: P];
	assign oy    = s_axis_tdata[3*T + 1*P +: P];
	assign oz    = s_axis_tdata[3*T + 2*P +: P];
	assign nx    = s_axis_tdata[3*T + 3*P +: P];
	assign ny    = s_axis_tdata[3*T + 4*P +: P];
	assign nz    = s_axis_tdata[3*T + 5*P +: P];
	assign oh    = s_axis_tdata[3*T + 6*P +: A];
	assign nh    = s_axis_tdata[3*T + 6*P + A +: A];

	// ---------------- stage 1: compares and differences ----------------
	logic                   pass_iv, lo_iv, hi_iv;
	logic [T:0]             dur_w, rem_w;
	logic signed [A+1:0]    hd_raw, hd_fold;
	carry_t                 carry_w;
	clamp_t                 clamp_w;

	assign pass_iv = $signed(t_new) <= $signed(t_old);
	assign lo_iv   = $signed(t_ren) <= $signed(t_old);
	assign hi_iv   = $signed(t_ren) >= $signed(t_new);
	assign dur_w   = {t_new[T-1], t_new} - {t_old[T-1], t_old};
	assign rem_w   = {t_ren[T-1], t_ren} - {t_old[T-1], t_old};

	// An empty or reversed interval uses alpha = one, which lands exactly on
	// the newer pose for every axis and for the folded heading.
	assign clamp_w.full = pass_iv || hi_iv;
	assign clamp_w.zero = !pass_iv && lo_iv;

	// Fold the heading difference into [-half turn, +half turn].
	assign hd_raw  = $signed({2'b00, nh}) - $signed({2'b00, oh});
	always_comb begin
		if (hd_raw > HALF_TURN) begin
			hd_fold = hd_raw - FULL_TURN;
		end else if (hd_raw < -HALF_TURN) begin
			hd_fold = hd_raw + FULL_TURN;
		end else begin
			hd_fold = hd_raw;
		end
	end

	assign carry_w.hd = hd_fold[A:0];
	assign carry_w.oh = oh;
	assign carry_w.dx = {nx[P-1], nx} - {ox[P-1], ox};
	assign carry_w.dy = {ny[P-1], ny} - {oy[P-1], oy};
	assign carry_w.dz = {nz[P-1], nz} - {oz[P-1], oz};
	assign carry_w.ox = ox;
	assign carry_w.oy = oy;
	assign carry_w.oz = oz;

	logic         vld_s1;
	logic [T-1:0] dur_s1, rem_s1;
	clamp_t       clamp_s1;
	carry_t       carry_s1;
	logic         adv_s1, div_in_ready;

	assign adv_s1        = !vld_s1 || div_in_ready;
	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			dur_s1   <= dur_w[T-1:0];
			rem_s1   <= rem_w[T-1:0];
			clamp_s1 <= clamp_w;
			carry_s1 <= carry_w;
		end
	end

	// ---------------- alpha divider ----------------
	logic         div_valid, adv_s2;
	logic [F-1:0] div_quo;
	clamp_t       div_clamp;
	logic [$bits(carry_t)-1:0] div_payload;
	carry_t       div_carry;

	spi_alpha_div #(
		.TIME_BITS    (T),
		.FRAC_BITS    (F),
		.PAYLOAD_BITS ($bits(carry_t))
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (vld_s1),
		.in_ready    (div_in_ready),
		.dur         (dur_s1),
		.rem         (rem_s1),
		.in_clamp    (clamp_s1),
		.in_payload  (carry_s1),
		.out_valid   (div_valid),
		.out_ready   (adv_s2),
		.quotient    (div_quo),
		.out_clamp   (div_clamp),
		.out_payload (div_payload)
	);

	assign div_carry = carry_t'(div_payload);

	// ---------------- stage 2: clamp alpha and multiply ----------------
	logic [F:0] alpha;

	always_comb begin
		if (div_clamp.full) begin
			alpha = ALPHA_ONE;
		end else if (div_clamp.zero) begin
			alpha = '0;
		end else begin
			alpha = {1'b0, div_quo};
		end
	end

	logic                      vld_s2, adv_s3;
	logic signed [PROD_W-1:0]  px_s2, py_s2, pz_s2;
	logic signed [HPROD_W-1:0] ph_s2;
	logic [P-1:0]              ox_s2, oy_s2, oz_s2;
	logic [A-1:0]              oh_s2;

	assign adv_s2 = !vld_s2 || adv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && div_valid) begin
			px_s2 <= PROD_W'($signed(div_carry.dx)) * PROD_W'($signed({1'b0, alpha}));
			py_s2 <= PROD_W'($signed(div_carry.dy)) * PROD_W'($signed({1'b0, alpha}));
			pz_s2 <= PROD_W'($signed(div_carry.dz)) * PROD_W'($signed({1'b0, alpha}));
			ph_s2 <= HPROD_W'($signed(div_carry.hd)) * HPROD_W'($signed({1'b0, alpha}));
			ox_s2 <= div_carry.ox;
			oy_s2 <= div_carry.oy;
			oz_s2 <= div_carry.oz;
			oh_s2 <= div_carry.oh;
		end
	end

	// ---------------- stage 3: floor scale, add, output register ----------------
	// Arithmetic shift right is floor division by the alpha scale.
	logic signed [PROD_W-1:0]  sx_w, sy_w, sz_w;
	logic signed [HPROD_W-1:0] sh_w;

	assign sx_w = px_s2 >>> F;
	assign sy_w = py_s2 >>> F;
	assign sz_w = pz_s2 >>> F;
	assign sh_w = ph_s2 >>> F;

	logic         vld_s3;
	logic [P-1:0] x_s3, y_s3, z_s3;
	logic [A-1:0] h_s3;

	assign adv_s3 = !vld_s3 || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	// The heading sum wraps modulo one turn by truncation.
	always_ff @(posedge clk) begin
		if (adv_s3 && vld_s2) begin
			x_s3 <= ox_s2 + sx_w[P-1:0];
			y_s3 <= oy_s2 + sy_w[P-1:0];
			z_s3 <= oz_s2 + sz_w[P-1:0];
			h_s3 <= oh_s2 + sh_w[A-1:0];
		end
	end

	assign m_axis_tvalid = vld_s3;
	assign m_axis_tdata  = OUT_TDATA_W'({h_s3, z_s3, y_s3, x_s3});

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam int IN_TDATA_W       = 320;
	localparam int OUT_TDATA_W      = 112;
	localparam int SINK_HOLD_CYCLES = 64;
	localparam int DRAIN_CYCLES     = 30;
	localparam int QUIET_LIMIT      = 2000;
	localparam int MAX_PRINTED      = 20;

	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

	// One pose pair with its timestamps, as it travels into the block.
	typedef struct {
		logic signed [31:0] older_time;
		logic signed [31:0] newer_time;
		logic signed [31:0] sample_time;
		logic signed [31:0] older_x;
		logic signed [31:0] older_y;
		logic signed [31:0] older_z;
		logic signed [31:0] newer_x;
		logic signed [31:0] newer_y;
		logic signed [31:0] newer_z;
		logic [15:0]        older_heading;
		logic [15:0]        newer_heading;
	} pose_pair_t;

	// One blended pose as it comes out.
	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [15:0]        heading;
	} pose_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	pose_t pose_expect_q[$];
	int    items_sent;
	int    poses_checked;
	int    mismatch_count;
	int    quiet_cycles;
	bit    src_gaps;
	bit    sink_gaps;
	bit    sink_hold_req;

	snapshot_pose_interpolator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Position blend: older + floor((newer - older) * alpha / 2^16), kept at 32 bits.
	function automatic logic [31:0] blend_axis(input longint a, input longint b,
			input longint alpha);
		longint v;
		v = a + (((b - a) * alpha) >>> 16);
		return v[31:0];
	endfunction

	// Work out the pose the block must give for one pose pair.
	function automatic pose_t interp_pose(input pose_pair_t p);
		pose_t  r;
		longint t0, t1, tr, alpha, dh, v;
		t0 = p.older_time;
		t1 = p.newer_time;
		tr = p.sample_time;
		// Empty or reversed interval: pass the newer pose straight through.
		if (t1 <= t0) begin
			r.x       = p.newer_x;
			r.y       = p.newer_y;
			r.z       = p.newer_z;
			r.heading = p.newer_heading;
			return r;
		end
		// Clamp alpha to [0, 1] in Q1.16; inside the interval the quotient truncates.
		if (tr <= t0)
			alpha = 0;
		else if (tr >= t1)
			alpha = 65536;
		else
			alpha = ((tr - t0) <<< 16) / (t1 - t0);
		r.x = blend_axis(p.older_x, p.newer_x, alpha);
		r.y = blend_axis(p.older_y, p.newer_y, alpha);
		r.z = blend_axis(p.older_z, p.newer_z, alpha);
		// Fold the heading step into [-half turn, +half turn]; exact half keeps its sign.
		dh = longint'(p.newer_heading) - longint'(p.older_heading);
		if (dh > 32768)
			dh -= 65536;
		if (dh < -32768)
			dh += 65536;
		v = longint'(p.older_heading) + ((dh * alpha) >>> 16);
		r.heading = v[15:0];
		return r;
	endfunction

	function automatic pose_pair_t mk_pose(input longint t0, input longint t1,
			input longint tr, input longint ox, input longint oy, input longint oz,
			input longint nx, input longint ny, input longint nz,
			input int unsigned oh, input int unsigned nh);
		pose_pair_t p;
		p.older_time    = 32'(t0);
		p.newer_time    = 32'(t1);
		p.sample_time   = 32'(tr);
		p.older_x       = 32'(ox);
		p.older_y       = 32'(oy);
		p.older_z       = 32'(oz);
		p.newer_x       = 32'(nx);
		p.newer_y       = 32'(ny);
		p.newer_z       = 32'(nz);
		p.older_heading = 16'(oh);
		p.newer_heading = 16'(nh);
		return p;
	endfunction

	// Mostly well-formed intervals with random spans and render points; the rest
	// have empty or arbitrary (often reversed) timestamps.
	function automatic pose_pair_t random_pose();
		pose_pair_t  p;
		longint      lo, dur;
		int unsigned kind;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			p.older_time  = $urandom;
			p.newer_time  = $urandom;
			p.sample_time = $urandom;
		end else if (kind == 1) begin
			p.older_time  = $urandom;
			p.newer_time  = p.older_time;
			p.sample_time = $urandom;
		end else begin
			case ($urandom_range(0, 2))
				0: dur = $urandom_range(1, 1000);
				1: dur = $urandom_range(1, 1 << 20);
				default: dur = longint'($urandom) + 1;
			endcase
			if (dur > 64'hFFFF_FFFF)
				dur = 64'hFFFF_FFFF;
			// Place the interval so that newer_time stays in range.
			lo = longint'($urandom) % (64'h1_0000_0000 - dur) - 64'h8000_0000;
			p.older_time = 32'(lo);
			p.newer_time = 32'(lo + dur);
			case ($urandom_range(0, 9))
				0: p.sample_time = $urandom;
				1: p.sample_time = 32'(lo);
				2: p.sample_time = 32'(lo + dur);
				default: p.sample_time = 32'(lo + 1 + longint'($urandom) % dur);
			endcase
		end
		p.older_x = $urandom;
		p.older_y = $urandom;
		p.older_z = $urandom;
		p.newer_x = ($urandom_range(0, 3) == 0) ? p.older_x + $urandom_range(0, 2000) - 1000
			: $urandom;
		p.newer_y = ($urandom_range(0, 3) == 0) ? p.older_y + $urandom_range(0, 2000) - 1000
			: $urandom;
		p.newer_z = ($urandom_range(0, 3) == 0) ? p.older_z + $urandom_range(0, 2000) - 1000
			: $urandom;
		p.older_heading = 16'($urandom);
		case ($urandom_range(0, 5))
			0: p.newer_heading = p.older_heading ^ 16'h8000;
			1: p.newer_heading = 16'(p.older_heading + $urandom_range(0, 64) - 32);
			default: p.newer_heading = 16'($urandom);
		endcase
		return p;
	endfunction

	// Offer one item from the falling edge and hold it until the block takes it.
	task automatic send_pose(input pose_pair_t p);
		int gap;
		@(negedge clk);
		if (src_gaps && $urandom_range(0, 2) == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {p.newer_heading, p.older_heading, p.newer_z, p.newer_y, p.newer_x,
			p.older_z, p.older_y, p.older_x, p.sample_time, p.newer_time, p.older_time};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pose_expect_q.push_back(interp_pose(p));
		items_sent++;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	// Drop valid, then wait until every outstanding pose is back plus some slack.
	task automatic wait_all_results();
		stop_sending();
		while (pose_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < MAX_PRINTED)
			$display("%0t: result %0d %s: got %h, want %h", $realtime, poses_checked, field,
				got, want);
		mismatch_count++;
	endtask

	// Extremes of every field and each corner of the clamp and heading fold.
	task automatic test_directed();
		// empty interval, reversed interval, reversed at the time extremes
		send_pose(mk_pose(100, 100, 50, 1, 2, 3, 4, 5, 6, 10, 20));
		send_pose(mk_pose(1000, -5, 500, S32_MIN, 0, S32_MAX, S32_MAX, -1, S32_MIN, 0, 16'hFFFF));
		send_pose(mk_pose(S32_MAX, S32_MIN, 0, 7, 8, 9, -7, -8, -9, 16'h1234, 16'h8000));
		// render before, at, and after the interval ends
		send_pose(mk_pose(0, 100, -50, 100, 200, 300, -100, -200, -300, 100, 200));
		send_pose(mk_pose(0, 100, 0, 100, 200, 300, -100, -200, -300, 100, 200));
		send_pose(mk_pose(0, 100, 100, 100, 200, 300, -100, -200, -300, 100, 200));
		send_pose(mk_pose(0, 100, S32_MAX, 100, 200, 300, -100, -200, -300, 100, 200));
		send_pose(mk_pose(S32_MIN, S32_MAX, S32_MIN, 1, 1, 1, 2, 2, 2, 3, 4));
		// midpoint across the full position range; z rounds toward minus infinity
		send_pose(mk_pose(0, 2, 1, S32_MIN, S32_MAX, 0, S32_MAX, S32_MIN, -1, 0, 16'h8000));
		// exactly half a turn in the negative direction
		send_pose(mk_pose(0, 2, 1, 0, 0, 0, 0, 0, 0, 16'h8000, 0));
		// heading step through zero both ways
		send_pose(mk_pose(0, 2, 1, 5, 5, 5, 5, 5, 5, 16'hFFF0, 16'h0010));
		send_pose(mk_pose(0, 2, 1, 5, 5, 5, 5, 5, 5, 16'h0010, 16'hFFF0));
		// just past half a turn folds to the short way round
		send_pose(mk_pose(0, 4, 1, 0, 0, 0, 400, 400, 400, 0, 16'h8001));
		// widest interval, render in the middle
		send_pose(mk_pose(S32_MIN, S32_MAX, 0, S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX,
			S32_MAX, 16'hFFFF, 0));
		// alpha just below one, and a render point just past the older time (alpha truncates to zero)
		send_pose(mk_pose(0, 65537, 65536, -1000, 1000, 0, 1000, -1000, 65536, 0, 16'h7FFF));
		send_pose(mk_pose(0, S32_MAX, 1, -1000, 1000, 0, 1000, -1000, 65536, 0, 16'h7FFF));
		// all ones everywhere (empty interval) and all zeros
		send_pose(mk_pose(-1, -1, -1, -1, -1, -1, -1, -1, -1, 16'hFFFF, 16'hFFFF));
		send_pose(mk_pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		stop_sending();
	endtask

	task automatic test_random(input int count);
		repeat (count) send_pose(random_pose());
		stop_sending();
	endtask

	// Hold the sink off for a long stretch while items keep coming, so the
	// pipeline fills and pushes back on the input.
	task automatic test_backpressure();
		src_gaps      = 1'b0;
		sink_hold_req = 1'b1;
		repeat (30) send_pose(random_pose());
		stop_sending();
		src_gaps = 1'b1;
	endtask

	// Pause the source until the pipeline is empty, then resume.
	task automatic test_drain_pause();
		repeat (40) send_pose(random_pose());
		wait_all_results();
		repeat (40) send_pose(random_pose());
		stop_sending();
	endtask

	// Back-to-back items with the sink always ready.
	task automatic test_full_rate();
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		repeat (60) send_pose(random_pose());
		stop_sending();
	endtask

	// Sink side: random ready bursts, plus one long hold on request.
	initial begin : sink_side
		int stall;
		stall         = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				stall         = SINK_HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
				stall         = $urandom_range(0, 3);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare every accepted pose with the oldest one outstanding.
	always @(posedge clk) begin : check_results
		pose_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pose_expect_q.size() == 0) begin
				report_mismatch("unexpected pose", m_axis_tdata[31:0], '0);
			end else begin
				want = pose_expect_q.pop_front();
				if (m_axis_tdata[31:0] !== want.x)
					report_mismatch("out_x", m_axis_tdata[31:0], want.x);
				if (m_axis_tdata[63:32] !== want.y)
					report_mismatch("out_y", m_axis_tdata[63:32], want.y);
				if (m_axis_tdata[95:64] !== want.z)
					report_mismatch("out_z", m_axis_tdata[95:64], want.z);
				if (m_axis_tdata[111:96] !== want.heading)
					report_mismatch("out_heading", m_axis_tdata[111:96], want.heading);
			end
			poses_checked++;
		end
	end

	// End the run if neither side moves an item for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: %0d cycles with no item moving", quiet_cycles);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		src_gaps       = 1'b1;
		sink_gaps      = 1'b1;
		sink_hold_req  = 1'b0;
		items_sent     = 0;
		poses_checked  = 0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(220);
		test_backpressure();
		test_drain_pause();
		test_full_rate();
		wait_all_results();

		$display("covered %0d pose pairs: clamps, empty and reversed intervals, half-turn folds,",
			items_sent);
		$display("random spans, a long sink stall and a drain pause; %0d poses compared",
			poses_checked);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/spi_pkg.sv
design/spi_alpha_div.sv
design/snapshot_pose_interpolator.sv
sim/tb_top.sv
